/* design/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, token codes and symbol table for the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    // token codes on the op field and in the operator stack
    localparam logic [2:0] TK_OPERAND = 3'd0;
    localparam logic [2:0] TK_PLUS    = 3'd1;
    localparam logic [2:0] TK_MINUS   = 3'd2;
    localparam logic [2:0] TK_TIMES   = 3'd3;
    localparam logic [2:0] TK_DIVIDE  = 3'd4;
    localparam logic [2:0] TK_OPEN    = 3'd5;
    localparam logic [2:0] TK_CLOSE   = 3'd6;
    localparam logic [2:0] TK_END     = 3'd7;

    // status codes on the result beat
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] operand_char;
    } token_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       expression_end;
        logic [1:0] status;
        logic       last;
    } result_t;

    // ASCII character of an operator code
    function automatic logic [7:0] sym_of(input logic [2:0] code);
        logic [7:0] s;
        case (code)
            TK_PLUS:   s = 8'h2B;
            TK_MINUS:  s = 8'h2D;
            TK_TIMES:  s = 8'h2A;
            TK_DIVIDE: s = 8'h2F;
            TK_OPEN:   s = 8'h28;
            TK_CLOSE:  s = 8'h29;
            default:   s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

/* design/itp_stack.sv */
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module itp_stack
    import itp_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [2:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [2:0]    wr_data
);

    logic [2:0] mem [DEPTH];
    logic [2:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix token stream to postfix symbols.
// ----------------------------------------------------------------------------
// Usage:
//   token channel (token_valid / token_stall / token) carries one token per
//   beat: operand, + - * /, open, close or end of expression.
//   result channel (result_valid / result_stall / result) carries one beat per
//   emitted symbol or status; the last beat of a token has last set.
//   A token is taken only while the sequencer is idle; token_stall is high
//   for the whole time the sequencer works on a token.
// Sequencing:
//   a token is accepted, then decided and acted on; a token that pops operators
//   pops one per cycle while the output register can take a beat, paced by the
//   single read port of the operator stack, which refreshes the top of stack
//   once per pop. Open parentheses left at end of expression are dropped from
//   the stack without a result beat.
// Reset:
//   rst_n clears the stack count, the sequencer and the output register.
//   Stack storage is not cleared; only entries below the count are read.
// Stall:
//   the output register holds its beat while result_stall is high; the
//   sequencer holds its pending pop until the register can take a new beat.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    token_valid,
    output logic    token_stall,
    input  token_t  token,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    tok_op_reg, tok_op_next;
    logic [7:0]    tok_char_reg, tok_char_next;
    logic [CW-1:0] count_reg, count_next;
    logic          first_reg, first_next;
    logic          loop_reg, loop_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_sym_reg, pend_sym_next;
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg, result_next;

    // stack port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [2:0]    top;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    itp_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (tok_op_reg)
    );

    logic    empty, full, out_free;
    logic    top_low, top_high, top_open;
    logic    do_pop, do_discard;
    logic    emit, need_emit, do_push;
    result_t emit_data;
    logic [1:0] close_status;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign out_free = !result_valid_reg || !result_stall;
    assign top_low  = (top == TK_PLUS) || (top == TK_MINUS);
    assign top_high = (top == TK_TIMES) || (top == TK_DIVIDE);
    assign top_open = (top == TK_OPEN);

    // pop decision on the current top of stack
    always_comb
    begin
        do_pop     = 1'b0;
        do_discard = 1'b0;
        case (tok_op_reg)
            TK_PLUS, TK_MINUS:
            begin
                // first look: pop one on +/-, pop to open on * or /
                do_pop = !empty && (first_reg ? (top_low || top_high)
                                              : (loop_reg && !top_open));
            end
            TK_TIMES, TK_DIVIDE:
            begin
                do_pop = !empty && first_reg && top_high;
            end
            TK_CLOSE:
            begin
                do_pop = !empty && !top_open;
            end
            TK_END:
            begin
                // flush: emit operators, drop unmatched opens
                do_pop     = !empty && !top_open;
                do_discard = !empty && top_open;
            end
            default:
            begin
                do_pop     = 1'b0;
                do_discard = 1'b0;
            end
        endcase
    end

    // final beat, if any, and push decision of a token once no more pops are due
    always_comb
    begin
        need_emit    = 1'b0;
        do_push      = 1'b0;
        close_status = empty ? ST_UNMATCHED : ST_OK;
        emit_data    = '{symbol: 8'h00, has_symbol: 1'b0, expression_end: 1'b0,
                         status: ST_OK, last: 1'b1};
        case (tok_op_reg)
            TK_OPERAND:
            begin
                need_emit = 1'b1;
                emit_data.symbol     = tok_char_reg;
                emit_data.has_symbol = 1'b1;
            end
            TK_PLUS, TK_MINUS, TK_TIMES, TK_DIVIDE, TK_OPEN:
            begin
                if (pend_valid_reg)
                begin
                    need_emit = 1'b1;
                    do_push   = 1'b1;
                    emit_data.symbol     = pend_sym_reg;
                    emit_data.has_symbol = 1'b1;
                end
                else if (full)
                begin
                    need_emit = 1'b1;
                    emit_data.status = ST_OVERFLOW;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            TK_CLOSE:
            begin
                need_emit = pend_valid_reg || empty;
                emit_data.symbol     = pend_valid_reg ? pend_sym_reg : 8'h00;
                emit_data.has_symbol = pend_valid_reg;
                emit_data.status     = close_status;
            end
            default:
            begin
                // end of expression
                need_emit = 1'b1;
                emit_data.symbol         = pend_valid_reg ? pend_sym_reg : 8'h00;
                emit_data.has_symbol     = pend_valid_reg;
                emit_data.expression_end = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        tok_op_next       = tok_op_reg;
        tok_char_next     = tok_char_reg;
        count_next        = count_reg;
        first_next        = first_reg;
        loop_next         = loop_reg;
        pend_valid_next   = pend_valid_reg;
        pend_sym_next     = pend_sym_reg;
        result_next       = result_reg;
        rd_en             = 1'b0;
        rd_addr           = AW'(count_reg - CW'(2));
        wr_en             = 1'b0;
        wr_addr           = count_reg[AW-1:0];
        emit              = 1'b0;

        case (state_reg)
            IDLE:
            begin
                if (token_valid)
                begin
                    // take the token and fetch the top of stack
                    tok_op_next     = token.op;
                    tok_char_next   = token.operand_char;
                    first_next      = 1'b1;
                    loop_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    rd_en           = !empty;
                    rd_addr         = AW'(count_reg - CW'(1));
                    state_next      = SCAN;
                end
            end
            SCAN:
            begin
                if (do_pop)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        // release the previous pop, it is not the last one
                        if (pend_valid_reg)
                        begin
                            emit = 1'b1;
                            result_next = '{symbol: pend_sym_reg, has_symbol: 1'b1,
                                            expression_end: 1'b0, status: ST_OK,
                                            last: 1'b0};
                        end
                        pend_sym_next   = sym_of(top);
                        pend_valid_next = 1'b1;
                        first_next      = 1'b0;
                        if (first_reg)
                        begin
                            loop_next = top_high;
                        end
                        count_next = count_reg - CW'(1);
                        rd_en      = (count_reg >= CW'(2));
                    end
                end
                else if (do_discard)
                begin
                    count_next = count_reg - CW'(1);
                    rd_en      = (count_reg >= CW'(2));
                end
                else if (!need_emit || out_free)
                begin
                    if (need_emit)
                    begin
                        emit        = 1'b1;
                        result_next = emit_data;
                    end
                    if (do_push)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    // drop the matching open parenthesis
                    if ((tok_op_reg == TK_CLOSE) && !empty)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    pend_valid_next = 1'b0;
                    state_next      = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            tok_op_reg       <= TK_OPERAND;
            tok_char_reg     <= 8'h00;
            count_reg        <= '0;
            first_reg        <= 1'b0;
            loop_reg         <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_sym_reg     <= 8'h00;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            tok_op_reg       <= tok_op_next;
            tok_char_reg     <= tok_char_next;
            count_reg        <= count_next;
            first_reg        <= first_next;
            loop_reg         <= loop_next;
            pend_valid_reg   <= pend_valid_next;
            pend_sym_reg     <= pend_sym_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign token_stall  = (state_reg != IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // stack count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // never overwrite a beat the receiver is holding off
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !emit)
        else $error("result overwritten while stalled");

    // a pending pop exists only while a token is in work
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == SCAN))
        else $error("pending pop outside token work");

    // an accepted token always starts the sequencer
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !token_stall) |=> (state_reg == SCAN))
        else $error("accepted token not processed");

endmodule
